// ----- hdl/smfc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the stereo mixer with fade envelope.
// No dependencies; the interfaces and the top level import this package.
package smfc_pkg;

   localparam int SAMPLE_W   = 16;   // Q1.15 sample width
   localparam int SUM_W      = 18;   // sum of two samples plus sign headroom
   localparam int LEN_W      = 24;   // fade length registers
   localparam int POS_W      = 48;   // sample position counter
   localparam int GAIN_W     = 17;   // unsigned Q1.16 gain, 65536 is unity
   localparam int PROD_W     = 36;   // shared 18 x 18 signed multiplier output
   localparam int CNT_W      = 5;    // division step counter
   localparam int CSR_ADDR_W = 3;    // byte address of two 32-bit registers
   localparam int CSR_DATA_W = 32;

   localparam int DIV_IN_STEPS  = 16; // quotient bits of the fade-in gain
   localparam int DIV_OUT_STEPS = 17; // quotient bits of the fade-out factor

   localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(65536);

   // Register index codes, taken from address bit 2.
   localparam logic REG_FADE_IN  = 1'b0;
   localparam logic REG_FADE_OUT = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] src0_left;
      logic signed [SAMPLE_W-1:0] src0_right;
      logic signed [SAMPLE_W-1:0] src1_left;
      logic signed [SAMPLE_W-1:0] src1_right;
      logic                       src0_valid;
      logic                       src1_valid;
      logic                       stop_request;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_left;
      logic signed [SAMPLE_W-1:0] out_right;
      logic                       fade_done;
   } rsp_type;

endpackage

// ----- hdl/smfc_req_if.sv -----
`timescale 1ns / 1ps
// Input channel of the mixer: valid/ready handshake carrying one stereo sample pair.
// Depends on smfc_pkg for the payload type.
interface smfc_req_if import smfc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/smfc_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel of the mixer: valid/ready handshake carrying one faded stereo sample.
// Depends on smfc_pkg for the payload type.
interface smfc_rsp_if import smfc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/stereo_mix_fade_clamp.sv -----
`timescale 1ns / 1ps
// Top level of the two-source stereo mixer with linear fade-in/fade-out and Q1.15 clamp.
// Depends on smfc_pkg, smfc_req_if and smfc_rsp_if.
//
//   Channel   Direction  Handshake            Contents
//   req_ch    in         valid/ready          two stereo samples, valid bits, stop request
//   rsp_ch    out        valid/ready          faded, clamped stereo sample, fade_done
//   csr_*     in/out     APB, pready tied 1   fade_in_samples at 0x0, fade_out_samples at 0x4
//
// One transfer on req_ch is worked on at a time by a small sequencer around one shared
// restoring divide step and one shared 18 x 18 multiplier. It runs setup, the fade-in
// divide steps while the fade-in runs, the fade-out divide steps while a fade-out runs, the
// gain and channel multiplies and a final state that registers the result and frees req_ch.
// A finished result waits in the output register while the next sample is already taken.
// Reset is synchronous and active high; it clears the position, the fade state and the
// fade length registers. A stalled rsp_ch only holds the sequencer at its final cycle.
module stereo_mix_fade_clamp
   import smfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   smfc_req_if.sink              req_ch,
   smfc_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SETUP  = 4'd1;
   localparam logic [3:0] S_DIVIN  = 4'd2;
   localparam logic [3:0] S_FOPREP = 4'd3;
   localparam logic [3:0] S_DIVOUT = 4'd4;
   localparam logic [3:0] S_MULG   = 4'd5;
   localparam logic [3:0] S_GAIN   = 4'd6;
   localparam logic [3:0] S_MULL   = 4'd7;
   localparam logic [3:0] S_MULR   = 4'd8;
   localparam logic [3:0] S_FIN    = 4'd9;

   // Control state.
   logic [3:0]       state_ff, state_in;
   logic [LEN_W-1:0] fade_in_len_ff, fade_in_len_in;
   logic [LEN_W-1:0] fade_out_len_ff, fade_out_len_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             fading_ff, fading_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Working registers of the current sample.
   logic signed [SUM_W-1:0]    l_ff, l_in;
   logic signed [SUM_W-1:0]    r_ff, r_in;
   logic [LEN_W-1:0]           pos_lo_ff, pos_lo_in;
   logic                       in_fade_ff, in_fade_in;
   logic [POS_W-1:0]           since_ff, since_in;
   logic [LEN_W-1:0]           rem_ff, rem_in;
   logic [LEN_W-1:0]           div_ff, div_in;
   logic [GAIN_W-1:0]          q_ff, q_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic                       done_ff, done_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [SAMPLE_W-1:0]        res_l_ff, res_l_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   // Shared datapath.
   logic                     div_shift;
   logic [LEN_W:0]           rem_sh;
   logic                     div_ge;
   logic [LEN_W-1:0]         rem_step;
   logic [GAIN_W-1:0]        q_step;
   logic signed [SUM_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;

   logic             req_xfer;
   logic             csr_write;
   logic [POS_W-1:0] start_new;
   logic             out_free;

   // Scale a product of a sample sum and a Q1.16 gain back to Q1.15: divide by 65536
   // truncating toward zero, then clamp to the 16-bit range.
   function automatic logic [SAMPLE_W-1:0] scale_q15(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] adj;
      logic signed [19:0]       t;
      adj = p + (p[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
      t   = 20'(adj >>> 16);
      if (t > 20'sd32767) begin
         scale_q15 = 16'h7FFF;
      end else if (t < -20'sd32768) begin
         scale_q15 = 16'h8000;
      end else begin
         scale_q15 = t[SAMPLE_W-1:0];
      end
   endfunction

   function automatic logic signed [SUM_W-1:0] sext(input logic signed [SAMPLE_W-1:0] s);
      sext = {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
   endfunction

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Configuration port: zero-wait APB, writes land on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[2])
         REG_FADE_IN:  csr_prdata = CSR_DATA_W'(fade_in_len_ff);
         REG_FADE_OUT: csr_prdata = CSR_DATA_W'(fade_out_len_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // One restoring division step. The fade-out division starts without a shift so that
   // its first step yields the integer bit of the factor.
   assign div_shift = !((state_ff == S_DIVOUT) && (cnt_ff == '0));
   assign rem_sh    = div_shift ? {rem_ff, 1'b0} : {1'b0, rem_ff};
   assign div_ge    = (rem_sh >= {1'b0, div_ff});
   assign rem_step  = div_ge ? LEN_W'(rem_sh - {1'b0, div_ff}) : rem_sh[LEN_W-1:0];
   assign q_step    = {q_ff[GAIN_W-2:0], div_ge};

   // Shared multiplier: gain times fade-out factor, then each channel sum times the gain.
   always_comb begin
      case (state_ff)
         S_MULG: begin
            mul_a = $signed({1'b0, gain_ff});
            mul_b = $signed({1'b0, q_ff});
         end
         S_MULL: begin
            mul_a = l_ff;
            mul_b = $signed({1'b0, gain_ff});
         end
         S_MULR: begin
            mul_a = r_ff;
            mul_b = $signed({1'b0, gain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // The first stop request pins the fade-out start to the sample that carries it.
   assign start_new = fading_ff ? start_ff : pos_ff;

   always_comb begin
      state_in        = state_ff;
      fade_in_len_in  = fade_in_len_ff;
      fade_out_len_in = fade_out_len_ff;
      pos_in          = pos_ff;
      fading_in       = fading_ff;
      start_in        = start_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      l_in            = l_ff;
      r_in            = r_ff;
      pos_lo_in       = pos_lo_ff;
      in_fade_in      = in_fade_ff;
      since_in        = since_ff;
      rem_in          = rem_ff;
      div_in          = div_ff;
      q_in            = q_ff;
      cnt_in          = cnt_ff;
      gain_in         = gain_ff;
      done_in         = done_ff;
      prod_in         = prod_ff;
      res_l_in        = res_l_ff;
      rsp_data_in     = rsp_data_ff;

      if (csr_write) begin
         case (csr_paddr[2])
            REG_FADE_IN:  fade_in_len_in  = csr_pwdata[LEN_W-1:0];
            REG_FADE_OUT: fade_out_len_in = csr_pwdata[LEN_W-1:0];
            default:      ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               fading_in  = fading_ff || req_ch.data.stop_request;
               start_in   = start_new;
               since_in   = pos_ff - start_new;
               pos_lo_in  = pos_ff[LEN_W-1:0];
               in_fade_in = (pos_ff[POS_W-1:LEN_W] == '0) &&
                            (pos_ff[LEN_W-1:0] < fade_in_len_ff);
               pos_in     = (pos_ff == '1) ? pos_ff : pos_ff + POS_W'(1);
               l_in = (req_ch.data.src0_valid ? sext(req_ch.data.src0_left) : '0) +
                      (req_ch.data.src1_valid ? sext(req_ch.data.src1_left) : '0);
               r_in = (req_ch.data.src0_valid ? sext(req_ch.data.src0_right) : '0) +
                      (req_ch.data.src1_valid ? sext(req_ch.data.src1_right) : '0);
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            gain_in = UNITY_GAIN;
            done_in = fading_ff && !(since_ff < POS_W'(fade_out_len_ff));
            if (in_fade_ff) begin
               rem_in   = pos_lo_ff;
               div_in   = fade_in_len_ff;
               q_in     = '0;
               cnt_in   = '0;
               state_in = S_DIVIN;
            end else begin
               state_in = S_FOPREP;
            end
         end
         S_DIVIN: begin
            rem_in = rem_step;
            q_in   = q_step;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_IN_STEPS - 1)) begin
               gain_in  = {1'b0, q_step[GAIN_W-2:0]};
               state_in = S_FOPREP;
            end
         end
         S_FOPREP: begin
            if (fading_ff && !done_ff) begin
               // Since is below the fade-out length here, so its low bits suffice.
               rem_in   = fade_out_len_ff - since_ff[LEN_W-1:0];
               div_in   = fade_out_len_ff;
               q_in     = '0;
               cnt_in   = '0;
               state_in = S_DIVOUT;
            end else begin
               q_in     = done_ff ? '0 : UNITY_GAIN;
               state_in = S_MULG;
            end
         end
         S_DIVOUT: begin
            rem_in = rem_step;
            q_in   = q_step;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_OUT_STEPS - 1)) begin
               state_in = S_MULG;
            end
         end
         S_MULG: begin
            prod_in  = mul_p;
            state_in = S_GAIN;
         end
         S_GAIN: begin
            gain_in  = prod_ff[GAIN_W+15:16];
            state_in = S_MULL;
         end
         S_MULL: begin
            prod_in  = mul_p;
            state_in = S_MULR;
         end
         S_MULR: begin
            res_l_in = scale_q15(prod_ff);
            prod_in  = mul_p;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_data_in.out_left  = res_l_ff;
               rsp_data_in.out_right = scale_q15(prod_ff);
               rsp_data_in.fade_done = done_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         fade_in_len_ff  <= '0;
         fade_out_len_ff <= '0;
         pos_ff          <= '0;
         fading_ff       <= 1'b0;
         start_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         fade_in_len_ff  <= fade_in_len_in;
         fade_out_len_ff <= fade_out_len_in;
         pos_ff          <= pos_in;
         fading_ff       <= fading_in;
         start_ff        <= start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff        <= l_in;
      r_ff        <= r_in;
      pos_lo_ff   <= pos_lo_in;
      in_fade_ff  <= in_fade_in;
      since_ff    <= since_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      gain_ff     <= gain_in;
      done_ff     <= done_in;
      prod_ff     <= prod_in;
      res_l_ff    <= res_l_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- hdl/smfc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the stereo mixer, bound to the top level.
// Depends on stereo_mix_fade_clamp for the bind target only.
module smfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] out_left,
   input logic [15:0] out_right,
   input logic        fade_done
);

   // A held result stays offered until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before its transfer");

   // Each sample is worked on by the sequencer: no new sample right after one is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while previous sample still in work");

   // A result cannot appear the cycle after its input transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // Past the fade-out end the gain is zero, so the output is silent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fade_done |-> (out_left == 16'h0000) && (out_right == 16'h0000))
      else $error("nonzero output after fade-out end");

endmodule

bind stereo_mix_fade_clamp smfc_checker u_smfc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .out_left  (rsp_ch.data.out_left),
   .out_right (rsp_ch.data.out_right),
   .fade_done (rsp_ch.data.fade_done)
);
